// ===== src/cma_pkg.sv =====
`timescale 1ns / 1ps
package cma_pkg;

  // Operation codes
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;

  // Field widths
  localparam int RES_W  = 63;
  localparam int OFS_W  = 31;
  localparam int PROD_W = 2 * RES_W;

  // Top of the 63-bit residue range, 2^63
  localparam logic [63:0] MOD_BASE = 64'h8000_0000_0000_0000;

  // Side data that rides along the multiply pipeline
  typedef struct packed {
    logic [1:0]       func;
    logic [OFS_W-1:0] k;
    logic [63:0]      lin;   // add (before final subtract) or finished subtract
  } tag_t;

endpackage

// ===== src/cma_mul126.sv =====
`timescale 1ns / 1ps
module cma_mul126 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  cma_pkg::tag_t                 in_tag,
  input  logic [cma_pkg::RES_W-1:0]     a,
  input  logic [cma_pkg::RES_W-1:0]     b,
  output logic                          out_valid,
  output cma_pkg::tag_t                 out_tag,
  output logic [cma_pkg::RES_W-1:0]     up,
  output logic [cma_pkg::RES_W-1:0]     lo
);
  import cma_pkg::*;

  logic [63:0]       p00;
  logic [62:0]       p01;
  logic [62:0]       p10;
  logic [61:0]       p11;
  logic [63:0]       mid;
  logic [63:0]       p00_d;
  logic [61:0]       p11_d;
  logic [PROD_W-1:0] prod;
  logic [2:0]        vld;
  tag_t              tag1;
  tag_t              tag2;
  tag_t              tag3;

  // Track valid bits through the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // Form four partial products from the 32-bit and 31-bit halves, sum the cross terms, then assemble
  always_ff @(posedge clk) begin
    if (en) begin
      p00   <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
      p01   <= {31'b0, a[31:0]} * {32'b0, b[62:32]};
      p10   <= {32'b0, a[62:32]} * {31'b0, b[31:0]};
      p11   <= {31'b0, a[62:32]} * {31'b0, b[62:32]};
      tag1  <= in_tag;
      mid   <= {1'b0, p01} + {1'b0, p10};
      p00_d <= p00;
      p11_d <= p11;
      tag2  <= tag1;
      prod  <= {p11_d, p00_d} + {30'b0, mid, 32'b0};
      tag3  <= tag2;
    end
  end

  assign out_valid = vld[2];
  assign out_tag   = tag3;
  assign up        = prod[PROD_W-1:RES_W];
  assign lo        = prod[RES_W-1:0];

endmodule

// ===== src/cma_fold.sv =====
`timescale 1ns / 1ps
module cma_fold (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  cma_pkg::tag_t                 in_tag,
  input  logic [cma_pkg::RES_W-1:0]     up,
  input  logic [cma_pkg::RES_W-1:0]     lo,
  output logic                          out_valid,
  output cma_pkg::tag_t                 out_tag,
  output logic [63:0]                   r
);
  import cma_pkg::*;

  logic [4:0]       vld;
  tag_t             tag4;
  tag_t             tag5;
  tag_t             tag6;
  tag_t             tag7;
  tag_t             tag8;
  logic [62:0]      q0;
  logic [61:0]      q1;
  logic [RES_W-1:0] lo4;
  logic [RES_W-1:0] lo5;
  logic [OFS_W-1:0] up2;
  logic [RES_W-1:0] lo2;
  logic [93:0]      t;
  logic [61:0]      pk;
  logic [63:0]      s1;
  logic [63:0]      s2;
  logic [RES_W-1:0] s3;
  logic [1:0]       carry;
  logic [1:0]       carry_next;
  logic [32:0]      ck;
  logic [63:0]      r_reg;

  // Track valid bits through the five stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // Combine the high-part product, add the carried terms, and scale the carries by k
  always_comb begin
    t          = {31'b0, q0} + {q1, 32'b0};
    s2         = {1'b0, s1[62:0]} + {2'b0, pk};
    carry_next = {1'b0, s1[63]} + {1'b0, s2[63]};
    ck         = ({2'b0, tag7.k} & {33{carry[0]}}) + ({1'b0, tag7.k, 1'b0} & {33{carry[1]}});
  end

  // Advance the fold stages
  always_ff @(posedge clk) begin
    if (en) begin
      // high part times k, split in two
      q0    <= {31'b0, up[31:0]} * {32'b0, in_tag.k};
      q1    <= {31'b0, up[62:32]} * {31'b0, in_tag.k};
      lo4   <= lo;
      tag4  <= in_tag;
      // split up*k at bit 63
      up2   <= t[93:63];
      lo2   <= t[62:0];
      lo5   <= lo4;
      tag5  <= tag4;
      // second fold product and low-part sum
      pk    <= {31'b0, up2} * {31'b0, tag5.k};
      s1    <= {1'b0, lo5} + {1'b0, lo2};
      tag6  <= tag5;
      // add second fold, collect carries at bit 63
      s3    <= s2[62:0];
      carry <= carry_next;
      tag7  <= tag6;
      tag8  <= tag7;
      // fold carries back in
      r_reg <= {1'b0, s3} + {31'b0, ck};
    end
  end

  assign out_valid = vld[4];
  assign r         = r_reg;
  assign out_tag   = tag8;

endmodule

// ===== src/crandall_modular_alu_top.sv =====
`timescale 1ns / 1ps
// Modular ALU for one RNS channel with modulus 2^63 - k: add, subtract or multiply
// two 63-bit residues per transaction, k supplied with each transaction. Fully
// pipelined: one transaction is accepted every cycle while the output is not held,
// and each result runs the multiply path (three stages for the 126-bit product,
// five for the three folds by k, one for the final conditional subtract). Add and
// subtract travel the same pipeline, so results leave in arrival order. When the
// output register is held by the downstream side, the whole pipeline stops.
module crandall_modular_alu_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[1:0], operand_a[64:2], operand_b[127:65], mod_offset[158:128], zero pad
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result[62:0], zero pad
  output logic [63:0]  m_axis_tdata
);
  import cma_pkg::*;

  logic [1:0]       func;
  logic [RES_W-1:0] operand_a;
  logic [RES_W-1:0] operand_b;
  logic [OFS_W-1:0] mod_offset;
  logic             en;
  logic [63:0]      sum;
  logic [63:0]      diff;
  logic [63:0]      m_in;
  tag_t             in_tag;
  logic             mul_valid;
  tag_t             mul_tag;
  logic [RES_W-1:0] up;
  logic [RES_W-1:0] lo;
  logic             fold_valid;
  tag_t             fold_tag;
  logic [63:0]      fold_r;
  logic [63:0]      m_out;
  logic [63:0]      pre;
  logic [63:0]      red;
  logic [RES_W-1:0] result_next;
  logic             out_valid;
  logic [RES_W-1:0] result;

  assign func       = s_axis_tdata[1:0];
  assign operand_a  = s_axis_tdata[64:2];
  assign operand_b  = s_axis_tdata[127:65];
  assign mod_offset = s_axis_tdata[158:128];

  // Advance every stage unless the output register is held
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // Add with one fold at bit 63, and subtract with the modulus added back on borrow
  always_comb begin
    m_in        = MOD_BASE - {33'b0, mod_offset};
    sum         = {1'b0, operand_a} + {1'b0, operand_b};
    diff        = {1'b0, operand_a} - {1'b0, operand_b};
    in_tag.func = func;
    in_tag.k    = mod_offset;
    unique case (func)
      FUNC_ADD: in_tag.lin = {1'b0, sum[62:0]} + (sum[63] ? {33'b0, mod_offset} : 64'd0);
      FUNC_SUB: in_tag.lin = (operand_a < operand_b) ? diff + m_in : diff;
      default:  in_tag.lin = '0;
    endcase
  end

  cma_mul126 u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_tag    (in_tag),
    .a         (operand_a),
    .b         (operand_b),
    .out_valid (mul_valid),
    .out_tag   (mul_tag),
    .up        (up),
    .lo        (lo)
  );

  cma_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mul_valid),
    .in_tag    (mul_tag),
    .up        (up),
    .lo        (lo),
    .out_valid (fold_valid),
    .out_tag   (fold_tag),
    .r         (fold_r)
  );

  // Final conditional subtract and result select
  always_comb begin
    m_out = MOD_BASE - {33'b0, fold_tag.k};
    pre   = (fold_tag.func == FUNC_MUL) ? fold_r : fold_tag.lin;
    red   = (pre >= m_out) ? pre - m_out : pre;
    unique case (fold_tag.func)
      FUNC_ADD: result_next = red[RES_W-1:0];
      FUNC_SUB: result_next = fold_tag.lin[RES_W-1:0];
      FUNC_MUL: result_next = red[RES_W-1:0];
      default:  result_next = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, result};

endmodule

// ===== src/cma_checker.sv =====
`timescale 1ns / 1ps
module cma_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  // Keep the pad bit of a result clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[63])
    else $error("result pad bit set");

  // Accept input whenever the output register is empty
  a_ready_empty: assert property (@(posedge clk)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Drop any result after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // No result right after reset
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result right after reset");

endmodule

bind crandall_modular_alu_top cma_checker u_cma_checker (.*);
